// File: rtl/stc_pkg.sv
// stc_pkg: widths, codes and color-matching weight generation for the tristimulus block
// self-contained; used by the channel interfaces and by spectral_tristimulus_chromaticity

package stc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int WEIGHT_W  = 16;
  localparam int PROD_W    = SAMPLE_W + WEIGHT_W;
  localparam int TRI_W     = 48;
  localparam int RATIO_W   = 16;
  localparam int SUM_W     = TRI_W + 2;
  localparam int DEN_W     = TRI_W + 5;
  localparam int NUM_W     = TRI_W + 5;
  localparam int DIVD_W    = 64;
  localparam int REM_W     = DEN_W - 1 + RATIO_W;
  localparam int N_RATIOS  = 5;

  localparam int NUM_SAMPLES_DEF    = 81;
  localparam int LAMBDA_MIN_NM_DEF  = 380;
  localparam int LAMBDA_STEP_NM_DEF = 5;

  typedef enum logic [1:0] {CMF_X, CMF_Y, CMF_Z} cmf_sel_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] x;
    logic signed [WEIGHT_W-1:0] y;
    logic signed [WEIGHT_W-1:0] z;
  } cmf_word_t;

  // lobe fit: x uses lobes 0..2, y 3..4, z 5..6 (tenths of nm, weights in thousandths)
  localparam int LOBE_N = 7;
  typedef logic [2:0] lobe_idx_t;

  localparam int          LOBE_W    [LOBE_N] = '{1056, 362, -65, 821, 286, 1217, 681};
  localparam int unsigned LOBE_MU10 [LOBE_N] = '{5998, 4420, 5011, 5688, 5309, 4370, 4590};
  localparam int unsigned LOBE_S1   [LOBE_N] = '{379, 160, 204, 469, 163, 118, 260};
  localparam int unsigned LOBE_S2   [LOBE_N] = '{310, 267, 262, 405, 311, 360, 138};
  localparam int unsigned LOBE_DEN1 [LOBE_N] = '{2*379*379, 2*160*160, 2*204*204,
                                                 2*469*469, 2*163*163, 2*118*118,
                                                 2*260*260};
  localparam int unsigned LOBE_DEN2 [LOBE_N] = '{2*310*310, 2*267*267, 2*262*262,
                                                 2*405*405, 2*311*311, 2*360*360,
                                                 2*138*138};

  localparam logic [63:0]        ONE_Q32   = 64'd4294967296;
  localparam logic [63:0]        LOG2E_Q30 = 64'd1549082005;
  localparam logic [63:0]        LN2_Q32   = 64'd2977044472;
  localparam logic signed [63:0] ROUND_DIV = 64'sd262144000;

  // one gaussian lobe in q32, exp evaluated as a 14-term series on the fraction
  function automatic logic [63:0] lobe_gauss(input logic signed [63:0] lam10,
                                             input lobe_idx_t j);
    logic signed [63:0] d;
    logic [63:0] ad, s, a, b, n, f, g, term, pos, neg;
    d = lam10 - 64'(LOBE_MU10[j]);
    s = (d < 0) ? 64'(LOBE_S1[j]) : 64'(LOBE_S2[j]);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    if (ad > 64'd10 * s) return 64'd0;
    if (d < 0) a = ((ad * ad) << 32) / LOBE_DEN1[j];
    else a = ((ad * ad) << 32) / LOBE_DEN2[j];
    b = ((a >> 16) * LOG2E_Q30) >> 14;
    n = b >> 32;
    if (n >= 64'd40) return 64'd0;
    f = b & 64'hFFFF_FFFF;
    g = (f * LN2_Q32) >> 32;
    term = ONE_Q32;
    pos = ONE_Q32;
    neg = 64'd0;
    term = ((term * g) >> 32) / 1;  neg = neg + term;
    term = ((term * g) >> 32) / 2;  pos = pos + term;
    term = ((term * g) >> 32) / 3;  neg = neg + term;
    term = ((term * g) >> 32) / 4;  pos = pos + term;
    term = ((term * g) >> 32) / 5;  neg = neg + term;
    term = ((term * g) >> 32) / 6;  pos = pos + term;
    term = ((term * g) >> 32) / 7;  neg = neg + term;
    term = ((term * g) >> 32) / 8;  pos = pos + term;
    term = ((term * g) >> 32) / 9;  neg = neg + term;
    term = ((term * g) >> 32) / 10; pos = pos + term;
    term = ((term * g) >> 32) / 11; neg = neg + term;
    term = ((term * g) >> 32) / 12; pos = pos + term;
    term = ((term * g) >> 32) / 13; neg = neg + term;
    return (pos - neg) >> n;
  endfunction

  // weight in signed q2.14 at a wavelength given in tenths of nm
  function automatic logic signed [WEIGHT_W-1:0] cmf_weight(input int unsigned lam10,
                                                            input cmf_sel_t sel);
    logic signed [63:0] total, wv, gv, q;
    logic [2:0] first;
    logic [1:0] cnt;
    lobe_idx_t  j;
    case (sel)
      CMF_X: begin first = 3'd0; cnt = 2'd3; end
      CMF_Y: begin first = 3'd3; cnt = 2'd2; end
      CMF_Z: begin first = 3'd5; cnt = 2'd2; end
      default: begin first = 3'd0; cnt = 2'd0; end
    endcase
    total = 64'sd0;
    for (int k = 0; k < 3; k++) begin
      if (k < int'(cnt)) begin
        j = lobe_idx_t'(first + 3'(k));
        gv = signed'(lobe_gauss(64'(lam10), j));
        wv = 64'(LOBE_W[j]);
        total = total + wv * gv;
      end
    end
    if (total >= 0) q = (total + ROUND_DIV / 2) / ROUND_DIV;
    else q = -((-total + ROUND_DIV / 2) / ROUND_DIV);
    return WEIGHT_W'(q);
  endfunction

endpackage

// File: rtl/stc_in_if.sv
// stc_in_if: sample request channel, valid/ready with sample and last flag
// depends on stc_pkg for field widths

interface stc_in_if import stc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

// File: rtl/stc_out_if.sv
// stc_out_if: result request channel, tristimulus sums and chromaticity
// depends on stc_pkg for field widths

interface stc_out_if import stc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TRI_W-1:0]  tri_x;
  logic signed [TRI_W-1:0]  tri_y;
  logic signed [TRI_W-1:0]  tri_z;
  logic [RATIO_W-1:0]       chroma_x;
  logic [RATIO_W-1:0]       chroma_y;
  logic [RATIO_W-1:0]       u_1960;
  logic [RATIO_W-1:0]       v_1960;
  logic [RATIO_W-1:0]       v_prime;
  logic                     chroma_valid;

  modport source (output valid, output tri_x, output tri_y, output tri_z,
                  output chroma_x, output chroma_y, output u_1960, output v_1960,
                  output v_prime, output chroma_valid, input ready);
  modport sink (input valid, input tri_x, input tri_y, input tri_z,
                input chroma_x, input chroma_y, input u_1960, input v_1960,
                input v_prime, input chroma_valid, output ready);
endinterface

// File: rtl/spectral_tristimulus_chromaticity.sv
// CIE 1931 tristimulus integrator with chromaticity (depends on stc_pkg, stc_in_if, stc_out_if).
// Each request carries one spectral sample; sample i of a spectrum belongs to wavelength
// LAMBDA_MIN_NM + i*LAMBDA_STEP_NM, and the color-matching weights come from a constant table
// built at elaboration. A positive sample in range is accepted, then makes one pass of the shared
// 16x16 multiplier each for X, Y and Z; a non-positive or out-of-range sample is only accepted.
// The request flagged last then passes scaling and sums, and per ratio (none if X+Y+Z is not
// positive, only x and y if X+15Y+3Z is not) a start step that settles a zero or saturated
// ratio, else the shared restoring divider (one quotient bit per cycle). The result sits in an
// output register, so the next spectrum is accepted while it waits; a finished result only
// waits when the previous one has not been taken yet. There is no clearing pass after reset.

module spectral_tristimulus_chromaticity import stc_pkg::*; #(
  parameter int NUM_SAMPLES    = NUM_SAMPLES_DEF,
  parameter int LAMBDA_MIN_NM  = LAMBDA_MIN_NM_DEF,
  parameter int LAMBDA_STEP_NM = LAMBDA_STEP_NM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  stc_in_if.sink    in_ch,
  stc_out_if.source out_ch
);

  localparam int IDX_W  = $clog2(NUM_SAMPLES + 1);
  localparam int ADDR_W = $clog2(NUM_SAMPLES);
  localparam int STEP_W = $clog2(LAMBDA_STEP_NM + 1) + 1;
  localparam int CNT_W  = $clog2(RATIO_W);
  localparam logic signed [STEP_W-1:0] STEP_S = STEP_W'(LAMBDA_STEP_NM);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC_X, S_MAC_Y, S_MAC_Z, S_SCALE, S_SUMS, S_DIV_START, S_DIV_STEP, S_FINISH
  } state_t;

  typedef enum logic [2:0] {RATIO_CX, RATIO_CY, RATIO_U, RATIO_V, RATIO_VP} ratio_t;

  // weight table
  cmf_word_t rom [NUM_SAMPLES];

  for (genvar gi = 0; gi < NUM_SAMPLES; gi++) begin : g_rom
    localparam int unsigned LAM10 = (LAMBDA_MIN_NM + gi * LAMBDA_STEP_NM) * 10;
    localparam logic signed [WEIGHT_W-1:0] WX = cmf_weight(LAM10, CMF_X);
    localparam logic signed [WEIGHT_W-1:0] WY = cmf_weight(LAM10, CMF_Y);
    localparam logic signed [WEIGHT_W-1:0] WZ = cmf_weight(LAM10, CMF_Z);
    assign rom[gi] = '{x: WX, y: WY, z: WZ};
  end

  state_t                     state_r;
  logic [IDX_W-1:0]           idx_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       last_r;
  cmf_word_t                  w_r;
  logic signed [TRI_W-1:0]    acc_x_r, acc_y_r, acc_z_r;
  logic signed [TRI_W-1:0]    tx_r, ty_r, tz_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [DEN_W-1:0]    den_r;
  logic                       sum_pos_r, den_pos_r;
  ratio_t                     ratio_r;
  logic [REM_W-1:0]           rem_r, dv_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [RATIO_W-1:0]         q_acc_r;
  logic [RATIO_W-1:0]         q_r [N_RATIOS];

  logic                       out_valid_r;
  logic signed [TRI_W-1:0]    out_tx_r, out_ty_r, out_tz_r;
  logic [RATIO_W-1:0]         out_q_r [N_RATIOS];
  logic                       out_cv_r;

  // accumulate path
  logic                       in_range;
  logic signed [WEIGHT_W-1:0] mac_w;
  logic signed [PROD_W-1:0]   mac_prod;

  assign in_range = idx_r < IDX_W'(NUM_SAMPLES);

  always_comb begin
    case (state_r)
      S_MAC_X: mac_w = w_r.x;
      S_MAC_Y: mac_w = w_r.y;
      S_MAC_Z: mac_w = w_r.z;
      default: mac_w = '0;
    endcase
  end

  assign mac_prod = sample_r * mac_w;

  // sums
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [DEN_W-1:0] den_nxt;

  assign sum_nxt = SUM_W'(tx_r) + SUM_W'(ty_r) + SUM_W'(tz_r);
  assign den_nxt = DEN_W'(tx_r) + (DEN_W'(ty_r) <<< 4) - DEN_W'(ty_r)
                   + (DEN_W'(tz_r) <<< 1) + DEN_W'(tz_r);

  // divider operand selection
  logic signed [NUM_W-1:0] num_sel;
  logic signed [DEN_W-1:0] den_sel;
  logic [DEN_W-2:0]        den_mag;
  logic [DIVD_W-1:0]       divd;
  logic                    div_zero, div_sat, div_ge, ratio_last;
  logic [REM_W-1:0]        rem_nxt;
  logic [RATIO_W-1:0]      q_nxt;

  always_comb begin
    case (ratio_r)
      RATIO_CX: num_sel = NUM_W'(tx_r);
      RATIO_CY: num_sel = NUM_W'(ty_r);
      RATIO_U:  num_sel = NUM_W'(tx_r) <<< 2;
      RATIO_V:  num_sel = (NUM_W'(ty_r) <<< 2) + (NUM_W'(ty_r) <<< 1);
      RATIO_VP: num_sel = (NUM_W'(ty_r) <<< 3) + NUM_W'(ty_r);
      default:  num_sel = '0;
    endcase
  end

  assign den_sel    = (ratio_r == RATIO_CX || ratio_r == RATIO_CY) ? DEN_W'(sum_r) : den_r;
  assign den_mag    = den_sel[DEN_W-2:0];
  assign divd       = DIVD_W'({num_sel[NUM_W-2:0], RATIO_W'(0)}) + DIVD_W'(den_mag >> 1);
  assign div_zero   = (num_sel <= 0) || (den_sel <= 0);
  assign div_sat    = REM_W'(divd) >= REM_W'({den_mag, RATIO_W'(0)});
  assign ratio_last = ratio_r == (den_pos_r ? RATIO_VP : RATIO_CY);
  assign div_ge     = rem_r >= dv_r;
  assign rem_nxt    = div_ge ? rem_r - dv_r : rem_r;
  assign q_nxt      = {q_acc_r[RATIO_W-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state_r != S_FINISH) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            sample_r <= in_ch.sample;
            last_r   <= in_ch.last;
            w_r      <= in_range ? rom[idx_r[ADDR_W-1:0]] : '0;
            if (in_range) idx_r <= idx_r + IDX_W'(1);
            if (in_range && in_ch.sample > 0) state_r <= S_MAC_X;
            else if (in_ch.last) state_r <= S_SCALE;
          end
        end
        S_MAC_X: begin
          acc_x_r <= acc_x_r + TRI_W'(mac_prod);
          state_r <= S_MAC_Y;
        end
        S_MAC_Y: begin
          acc_y_r <= acc_y_r + TRI_W'(mac_prod);
          state_r <= S_MAC_Z;
        end
        S_MAC_Z: begin
          acc_z_r <= acc_z_r + TRI_W'(mac_prod);
          state_r <= last_r ? S_SCALE : S_IDLE;
        end
        S_SCALE: begin
          tx_r    <= acc_x_r * STEP_S;
          ty_r    <= acc_y_r * STEP_S;
          tz_r    <= acc_z_r * STEP_S;
          acc_x_r <= '0;
          acc_y_r <= '0;
          acc_z_r <= '0;
          idx_r   <= '0;
          state_r <= S_SUMS;
        end
        S_SUMS: begin
          sum_r     <= sum_nxt;
          den_r     <= den_nxt;
          sum_pos_r <= sum_nxt > 0;
          den_pos_r <= den_nxt > 0;
          ratio_r   <= RATIO_CX;
          for (int k = 0; k < N_RATIOS; k++) q_r[k] <= '0;
          state_r   <= (sum_nxt > 0) ? S_DIV_START : S_FINISH;
        end
        S_DIV_START: begin
          if (div_zero || div_sat) begin
            q_r[ratio_r] <= div_zero ? '0 : '1;
            if (ratio_last) state_r <= S_FINISH;
            else ratio_r <= ratio_t'(ratio_r + 3'd1);
          end else begin
            rem_r   <= REM_W'(divd);
            dv_r    <= REM_W'({den_mag, (RATIO_W - 1)'(0)});
            cnt_r   <= CNT_W'(RATIO_W - 1);
            state_r <= S_DIV_STEP;
          end
        end
        S_DIV_STEP: begin
          rem_r   <= rem_nxt;
          dv_r    <= dv_r >> 1;
          q_acc_r <= q_nxt;
          cnt_r   <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            q_r[ratio_r] <= q_nxt;
            if (ratio_last) state_r <= S_FINISH;
            else begin
              ratio_r <= ratio_t'(ratio_r + 3'd1);
              state_r <= S_DIV_START;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_tx_r    <= tx_r;
            out_ty_r    <= ty_r;
            out_tz_r    <= tz_r;
            for (int k = 0; k < N_RATIOS; k++) out_q_r[k] <= q_r[k];
            out_cv_r    <= sum_pos_r && den_pos_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.tri_x        = out_tx_r;
  assign out_ch.tri_y        = out_ty_r;
  assign out_ch.tri_z        = out_tz_r;
  assign out_ch.chroma_x     = out_q_r[RATIO_CX];
  assign out_ch.chroma_y     = out_q_r[RATIO_CY];
  assign out_ch.u_1960       = out_q_r[RATIO_U];
  assign out_ch.v_1960       = out_q_r[RATIO_V];
  assign out_ch.v_prime      = out_q_r[RATIO_VP];
  assign out_ch.chroma_valid = out_cv_r;

  // sample index never runs past the table
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(NUM_SAMPLES))
    else $error("sample index beyond table");

  // restoring divider keeps the partial remainder below twice the shifted divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_STEP) |-> ({1'b0, rem_r} < {dv_r, 1'b0}))
    else $error("divider remainder out of range");

  // a result only appears after the finish step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside finish");

endmodule
